// ===== sv/mdio_pkg.sv =====
// Shared types and constants for the clause 22 management master.
// Used by the front, queue and engine modules and by the top level.
package mdio_pkg;

	localparam int IDX_W      = 7;
	localparam int FRAME_W    = 32;
	localparam int DATA_W     = 16;
	localparam int ADDR_W     = 5;
	localparam int HDR_BITS   = 14;

	localparam logic [FRAME_W-1:0] READ_FRAME  = 32'h6000_0000;
	localparam logic [FRAME_W-1:0] WRITE_FRAME = 32'h5002_0000;

	// input op codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	typedef enum logic [1:0] {
		KIND_TICK     = 2'd0,
		KIND_START_RD = 2'd1,
		KIND_START_WR = 2'd2,
		KIND_NOP      = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [FRAME_W-1:0] frame;
		logic               din;
	} entry_t;

	typedef struct packed {
		logic              mdio_out;
		logic              mdio_oe;
		logic [DATA_W-1:0] read_data;
		logic              done_res;
		logic              busy_res;
		logic              rejected;
	} res_t;

endpackage

// ===== sv/mdio_front.sv =====
// Front end: decodes the incoming op and builds the 32-bit frame word on a start.
// Depends on mdio_pkg.
module mdio_front import mdio_pkg::*; (
	input  logic [1:0]        op,
	input  logic [ADDR_W-1:0] phy_addr,
	input  logic [ADDR_W-1:0] reg_addr,
	input  logic [DATA_W-1:0] write_data,
	input  logic              mdio_in,
	output entry_t            entry
);

	logic [FRAME_W-1:0] base;

	always_comb begin
		unique case (op)
			OP_TICK:  entry.kind = KIND_TICK;
			OP_READ:  entry.kind = KIND_START_RD;
			OP_WRITE: entry.kind = KIND_START_WR;
			default:  entry.kind = KIND_NOP;
		endcase
		// write data sits in the low half of a write frame
		base = (op == OP_READ) ? READ_FRAME : (WRITE_FRAME | FRAME_W'(write_data));
		entry.frame = base | (FRAME_W'(phy_addr) << 23) | (FRAME_W'(reg_addr) << 18);
		entry.din   = mdio_in;
	end

endmodule

// ===== sv/mdio_queue.sv =====
// Two-entry queue between the front end and the bit engine.
// Depends on mdio_pkg.
module mdio_queue import mdio_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   valid,
	output entry_t head
);

	entry_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/mdio_engine.sv =====
// Bit engine: runs the preamble/header/turnaround/data sequence, one entry per cycle
// while the output register that holds each result can take it. Depends on mdio_pkg.
module mdio_engine import mdio_pkg::*; #(
	parameter int PREAMBLE_BITS = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	input  entry_t in_entry,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output res_t   out_res
);

	localparam logic [IDX_W-1:0] PRE_END  = IDX_W'(PREAMBLE_BITS);
	localparam logic [IDX_W-1:0] HDR_END  = IDX_W'(PREAMBLE_BITS + HDR_BITS);
	localparam logic [IDX_W-1:0] TA2_IDX  = IDX_W'(PREAMBLE_BITS + HDR_BITS + 1);
	localparam logic [IDX_W-1:0] DATA_END = IDX_W'(PREAMBLE_BITS + HDR_BITS + 2 + DATA_W);

	logic               active_q;
	logic               is_read_q;
	logic [IDX_W-1:0]   idx_q;
	logic [FRAME_W-1:0] frame_q;
	logic [DATA_W-1:0]  rshift_q;
	logic               out_valid_q;
	res_t               res_q;

	logic               active_n;
	logic               is_read_n;
	logic [IDX_W-1:0]   idx_n;
	logic [FRAME_W-1:0] frame_n;
	logic [DATA_W-1:0]  rshift_n;
	res_t               res_n;

	assign pop       = in_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	always_comb begin
		active_n  = active_q;
		is_read_n = is_read_q;
		idx_n     = idx_q;
		frame_n   = frame_q;
		rshift_n  = rshift_q;

		res_n.mdio_out  = 1'b1;
		res_n.mdio_oe   = 1'b0;
		res_n.read_data = '0;
		res_n.done_res  = 1'b0;
		res_n.busy_res  = active_q;
		res_n.rejected  = 1'b0;

		unique case (in_entry.kind)
			KIND_START_RD, KIND_START_WR: begin
				res_n.busy_res = 1'b1;
				if (active_q) begin
					res_n.rejected = 1'b1;
				end else begin
					is_read_n = (in_entry.kind == KIND_START_RD);
					frame_n   = in_entry.frame;
					rshift_n  = '0;
					idx_n     = '0;
					active_n  = 1'b1;
				end
			end
			KIND_TICK: begin
				if (active_q) begin
					idx_n = idx_q + IDX_W'(1);
					if (idx_q < PRE_END) begin
						res_n.mdio_oe = 1'b1;
					end else if (idx_q < HDR_END) begin
						res_n.mdio_oe  = 1'b1;
						res_n.mdio_out = frame_q[FRAME_W-1];
						frame_n        = frame_q << 1;
					end else if (idx_q == HDR_END) begin
						res_n.mdio_oe = 1'b1;
						frame_n       = frame_q << 1;
					end else if (idx_q == TA2_IDX) begin
						// read releases the line, write drives 0
						res_n.mdio_oe  = ~is_read_q;
						res_n.mdio_out = is_read_q;
						frame_n        = frame_q << 1;
					end else if (idx_q < DATA_END) begin
						if (is_read_q) begin
							rshift_n = {rshift_q[DATA_W-2:0], in_entry.din};
						end else begin
							res_n.mdio_oe  = 1'b1;
							res_n.mdio_out = frame_q[FRAME_W-1];
							frame_n        = frame_q << 1;
						end
					end else begin
						res_n.read_data = is_read_q ? rshift_q : '0;
						res_n.done_res  = 1'b1;
						res_n.busy_res  = 1'b0;
						active_n        = 1'b0;
						idx_n           = '0;
					end
				end
			end
			default: begin
				// reserved op: idle result, state holds
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			is_read_q   <= 1'b0;
			idx_q       <= '0;
			frame_q     <= '0;
			rshift_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q  <= active_n;
				is_read_q <= is_read_n;
				idx_q     <= idx_n;
				frame_q   <= frame_n;
				rshift_q  <= rshift_n;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= res_n;
		end
	end

endmodule

// ===== sv/mdio_clause22_master_top.sv =====
// Top level of the clause 22 management master: front end, queue and bit engine.
// Depends on mdio_pkg, mdio_front, mdio_queue and mdio_engine.
//
// Every input word yields exactly one output word. Words are taken one per cycle while
// the queue is not full; a result passes through the queue and then the engine's
// output register. The sustained rate is one word per cycle while the output side is
// ready, set by the bit engine, which retires one queued word per cycle into its output
// register. A transaction is a start
// word followed by PREAMBLE_BITS + 33 tick words, each tick being one management
// clock bit period; the final tick carries tlast (done) and, on a read, the data.
// A start while a transaction runs returns a word with the rejected flag set.
module mdio_clause22_master_top import mdio_pkg::*; #(
	parameter int PREAMBLE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // phy_addr[4:0], reg_addr[9:5], write_data[25:10], mdio_in[26]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // mdio_out[0], mdio_oe[1], read_data[17:2], busy_res[18]
	output logic        m_tuser,   // rejected
	output logic        m_tlast    // done_res
);

	entry_t front_entry;
	entry_t head;
	logic   q_full;
	logic   q_valid;
	logic   q_pop;
	logic   push;
	res_t   res;

	assign s_tready = ~q_full;
	assign push     = s_tvalid && ~q_full;

	mdio_front u_front (
		.op         (s_tuser),
		.phy_addr   (s_tdata[4:0]),
		.reg_addr   (s_tdata[9:5]),
		.write_data (s_tdata[25:10]),
		.mdio_in    (s_tdata[26]),
		.entry      (front_entry)
	);

	mdio_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (front_entry),
		.full       (q_full),
		.pop        (q_pop),
		.valid      (q_valid),
		.head       (head)
	);

	mdio_engine #(
		.PREAMBLE_BITS (PREAMBLE_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_entry  (head),
		.pop       (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {5'd0, res.busy_res, res.read_data, res.mdio_oe, res.mdio_out};
	assign m_tuser = res.rejected;
	assign m_tlast = res.done_res;

endmodule
